// ----- rtl/abps_pkg.sv -----
// Shared types and constants for the alarm beep pattern sequencer.
// No dependencies; imported by every module of the block.
package abps_pkg;

   localparam int COUNT_W = 14;
   localparam int BEEP_W  = 3;
   localparam int REG_W   = 16;
   localparam int NUM_REGS = 4;

   localparam logic [BEEP_W-1:0] FIRST_BURST_BEEPS  = 3'd3;
   localparam logic [BEEP_W-1:0] SECOND_BURST_BEEPS = 3'd2;
   localparam logic [7:0]        SOUND_DUTY         = 8'd125;

   // x / 5 == (x * 52429) >> 18, exact for any 16-bit x
   localparam logic [REG_W-1:0] TICK_DIV_MULT  = 16'd52429;
   localparam int               TICK_DIV_SHIFT = 18;

   typedef enum logic [1:0] {
      REG_ON    = 2'd0,
      REG_OFF   = 2'd1,
      REG_SPACE = 2'd2,
      REG_PAUSE = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      TONE_OFF     = 2'd0,
      TONE_MEDIUM  = 2'd1,
      TONE_HIGH    = 2'd2,
      TONE_INVALID = 2'd3
   } tone_type;

   typedef enum logic [2:0] {
      PH_INACTIVE = 3'd0,
      PH_INITIATE = 3'd1,
      PH_ON       = 3'd2,
      PH_OFF      = 3'd3,
      PH_SPACE    = 3'd4,
      PH_ON2      = 3'd5,
      PH_OFF2     = 3'd6,
      PH_PAUSE    = 3'd7
   } phase_type;

   // tick counts derived from the millisecond registers
   typedef struct packed {
      logic [COUNT_W-1:0] on_cnt;
      logic [COUNT_W-1:0] off_cnt;
      logic [COUNT_W-1:0] space_cnt;
      logic [COUNT_W-1:0] pause_cnt;
   } counts_type;

   typedef struct packed {
      logic       action;   // 1 = tone request, 0 = tick
      logic [1:0] tone;
   } item_type;

   typedef struct packed {
      logic       sound_on;
      logic [7:0] pwm_compare;
      logic [2:0] phase;
   } result_type;

endpackage

// ----- rtl/abps_csr.sv -----
// Configuration registers with APB-style access.
// Each write also stores the value divided by 5 (tick count). Uses abps_pkg.
module abps_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [3:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output abps_pkg::counts_type counts
);
   import abps_pkg::*;

   logic [REG_W-1:0]      regs_ff [NUM_REGS];
   logic [COUNT_W-1:0]    cnt_ff  [NUM_REGS];
   logic [2*REG_W-1:0]    prod;
   logic [COUNT_W-1:0]    quot;
   logic [1:0]            idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign prod       = {{REG_W{1'b0}}, csr_pwdata[REG_W-1:0]} *
                       {{REG_W{1'b0}}, TICK_DIV_MULT};
   assign quot       = prod[TICK_DIV_SHIFT +: COUNT_W];
   assign csr_prdata = {16'd0, regs_ff[idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         regs_ff[idx] <= csr_pwdata[REG_W-1:0];
         cnt_ff[idx]  <= quot;
      end
   end

   assign counts.on_cnt    = cnt_ff[REG_ON];
   assign counts.off_cnt   = cnt_ff[REG_OFF];
   assign counts.space_cnt = cnt_ff[REG_SPACE];
   assign counts.pause_cnt = cnt_ff[REG_PAUSE];

endmodule

// ----- rtl/abps_in_stage.sv -----
// Input register stage of the item pipeline.
// Holds one item; refills in the cycle it drains. Uses abps_pkg.
module abps_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  abps_pkg::item_type up_item,
   output logic               dn_valid,
   input  logic               dn_ready,
   output abps_pkg::item_type dn_item
);
   import abps_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         item_ff <= up_item;
      end
   end

endmodule

// ----- rtl/abps_engine.sv -----
// Phase machine and result register: one tick or request per cycle while out_ready holds.
// Uses abps_pkg; tick counts come from abps_csr.
module abps_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  abps_pkg::item_type   in_item,
   input  abps_pkg::counts_type counts,
   output logic                 out_valid,
   input  logic                 out_ready,
   output abps_pkg::result_type out_result
);
   import abps_pkg::*;

   phase_type          phase_ff,  phase_in;
   logic [COUNT_W-1:0] wait_ff,   wait_in;
   logic [BEEP_W-1:0]  beeps_ff,  beeps_in;
   tone_type           tone_ff,   tone_in;
   counts_type         lat_ff,    lat_in;
   logic               sound_ff,  sound_in;
   logic               valid_ff;
   result_type         result_ff, result_in;
   logic               take;
   logic               expired;
   logic [COUNT_W-1:0] wait_dec;
   logic               tone_run;

   assign in_ready   = !valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      phase_in = phase_ff;
      wait_in  = wait_ff;
      beeps_in = beeps_ff;
      tone_in  = tone_ff;
      lat_in   = lat_ff;
      sound_in = sound_ff;
      expired  = (wait_ff <= COUNT_W'(1));
      wait_dec = expired ? '0 : wait_ff - COUNT_W'(1);
      tone_run = (tone_ff == TONE_MEDIUM) || (tone_ff == TONE_HIGH);

      if (in_item.action) begin
         lat_in  = counts;
         tone_in = tone_type'(in_item.tone);
         if (tone_in == TONE_MEDIUM || tone_in == TONE_HIGH) begin
            phase_in = PH_INITIATE;
         end else begin
            phase_in = PH_INACTIVE;
            if (tone_in == TONE_OFF) begin
               sound_in = 1'b0;
               beeps_in = '0;
            end
         end
      end else begin
         case (phase_ff)
            PH_INITIATE: begin
               if (tone_run && FIRST_BURST_BEEPS != '0 && lat_ff.on_cnt != '0) begin
                  wait_in  = lat_ff.on_cnt;
                  beeps_in = FIRST_BURST_BEEPS;
                  phase_in = PH_ON;
                  sound_in = 1'b1;
               end else begin
                  phase_in = PH_INACTIVE;
               end
            end
            PH_ON, PH_ON2: begin
               wait_in = wait_dec;
               if (expired) begin
                  sound_in = 1'b0;
                  beeps_in = beeps_ff - BEEP_W'(1);
                  if (lat_ff.off_cnt != '0) begin
                     phase_in = (phase_ff == PH_ON) ? PH_OFF : PH_OFF2;
                     wait_in  = lat_ff.off_cnt;
                  end else begin
                     phase_in = PH_INACTIVE;
                  end
               end
            end
            PH_OFF: begin
               wait_in = wait_dec;
               if (expired) begin
                  if (beeps_ff == '0) begin
                     sound_in = 1'b0;
                     if (tone_ff == TONE_MEDIUM) begin
                        phase_in = PH_PAUSE;
                        wait_in  = lat_ff.pause_cnt;
                     end else begin
                        phase_in = PH_SPACE;
                        wait_in  = lat_ff.space_cnt;
                     end
                  end else begin
                     phase_in = PH_ON;
                     wait_in  = lat_ff.on_cnt;
                     sound_in = 1'b1;
                  end
               end
            end
            PH_SPACE: begin
               wait_in = wait_dec;
               if (expired) begin
                  if (tone_ff == TONE_HIGH && SECOND_BURST_BEEPS != '0 &&
                      lat_ff.on_cnt != '0) begin
                     wait_in  = lat_ff.on_cnt;
                     beeps_in = SECOND_BURST_BEEPS;
                     phase_in = PH_ON2;
                     sound_in = 1'b1;
                  end else begin
                     phase_in = PH_INACTIVE;
                  end
               end
            end
            PH_OFF2: begin
               wait_in = wait_dec;
               if (expired) begin
                  if (beeps_ff == '0) begin
                     sound_in = 1'b0;
                     phase_in = PH_PAUSE;
                     wait_in  = lat_ff.pause_cnt;
                  end else begin
                     phase_in = PH_ON2;
                     wait_in  = lat_ff.on_cnt;
                     sound_in = 1'b1;
                  end
               end
            end
            PH_PAUSE: begin
               wait_in = wait_dec;
               if (expired) begin
                  phase_in = PH_INITIATE;
               end
            end
            default: begin
            end
         endcase
      end

      result_in.sound_on    = sound_in;
      result_in.pwm_compare = sound_in ? SOUND_DUTY : 8'd0;
      result_in.phase       = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_INACTIVE;
         wait_ff  <= '0;
         beeps_ff <= '0;
         tone_ff  <= TONE_OFF;
         lat_ff   <= '0;
         sound_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (take) begin
            phase_ff <= phase_in;
            wait_ff  <= wait_in;
            beeps_ff <= beeps_in;
            tone_ff  <= tone_in;
            lat_ff   <= lat_in;
            sound_ff <= sound_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

endmodule

// ----- rtl/alarm_beep_pattern_sequencer.sv -----
// Alarm beep pattern sequencer: top level, input stage, engine and registers.
// An accepted item passes the input register and then the result register.
// One item per cycle unless rsp_tready stalls; each item does one phase update.
// Reset (synchronous, active high) clears registers, tick counts, phase, sound and valids.
// Depends on abps_pkg, abps_csr, abps_in_stage, abps_engine.
module alarm_beep_pattern_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [1:0] tone, rest zero
   input  logic [0:0]  req_tuser,    // [0] action: 1 request, 0 tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [0] sound_on, [8:1] pwm_compare, [11:9] phase
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import abps_pkg::*;

   item_type   req_item;
   item_type   s1_item;
   logic       s1_valid;
   logic       s1_ready;
   counts_type counts;
   result_type result;

   assign req_item.action = req_tuser[0];
   assign req_item.tone   = req_tdata[1:0];

   abps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .counts      (counts)
   );

   abps_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .up_item  (req_item),
      .dn_valid (s1_valid),
      .dn_ready (s1_ready),
      .dn_item  (s1_item)
   );

   abps_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid),
      .in_ready   (s1_ready),
      .in_item    (s1_item),
      .counts     (counts),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {4'd0, result.phase, result.pwm_compare, result.sound_on};

   // beep phases always report a sounding buzzer
   a_on_sounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (result.phase == PH_ON || result.phase == PH_ON2) |-> result.sound_on)
      else $error("beep phase without sound");

   // gap phases are always silent
   a_gap_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (result.phase == PH_OFF || result.phase == PH_OFF2 ||
                     result.phase == PH_SPACE || result.phase == PH_PAUSE)
      |-> !result.sound_on && result.pwm_compare == 8'd0)
      else $error("gap phase with sound");

   // nothing in flight right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid)
      else $error("item in flight after reset");

endmodule

// ----- test/abps_pattern_checker.sv -----
// Checker for the alarm beep pattern sequencer: follows the request, result and
// register channels, predicts every result and compares field by field.
// Depends on abps_pkg.
module abps_pattern_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [1:0] tone, rest zero
   input  logic [0:0]  req_tuser,    // [0] action: 1 request, 0 tick
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // [0] sound_on, [8:1] pwm_compare, [11:9] phase
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import abps_pkg::*;

   localparam int TICK_MS    = 5;
   localparam int MAX_SHOWN  = 10;

   logic [REG_W-1:0]   ms_reg   [NUM_REGS];
   logic [COUNT_W-1:0] tick_cnt [NUM_REGS];
   phase_type          ph;
   logic [COUNT_W-1:0] wait_cnt;
   logic [BEEP_W-1:0]  beeps;
   tone_type           tone_q;
   logic               buzzing;
   result_type         beep_expect_q[$];
   int                 failures = 0;

   assign fail_count = failures;

   function automatic void flag_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
      failures++;
      if (failures <= MAX_SHOWN)
         $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want_v, got_v);
   endfunction

   // counts never wrap: zero or one expires on this tick
   function automatic logic count_expired();
      if (wait_cnt <= 1) begin
         wait_cnt = '0;
         return 1'b1;
      end
      wait_cnt = wait_cnt - 1'b1;
      return 1'b0;
   endfunction

   function automatic void start_burst(logic [BEEP_W-1:0] n, phase_type on_ph);
      if (n != 0 && tick_cnt[REG_ON] != 0) begin
         wait_cnt = tick_cnt[REG_ON];
         beeps    = n;
         ph       = on_ph;
         buzzing  = 1'b1;
      end else begin
         ph = PH_INACTIVE;
      end
   endfunction

   function automatic void end_beep(phase_type off_ph);
      buzzing = 1'b0;
      beeps   = beeps - 1'b1;
      if (tick_cnt[REG_OFF] != 0) begin
         ph       = off_ph;
         wait_cnt = tick_cnt[REG_OFF];
      end else begin
         ph = PH_INACTIVE;
      end
   endfunction

   function automatic void tone_request(tone_type t);
      for (int i = 0; i < NUM_REGS; i++)
         tick_cnt[i] = COUNT_W'(ms_reg[i] / TICK_MS);
      tone_q = t;
      if (t == TONE_MEDIUM || t == TONE_HIGH) begin
         ph = PH_INITIATE;
      end else begin
         // an invalid tone stops the sequence but leaves the buzzer alone
         ph = PH_INACTIVE;
         if (t == TONE_OFF) begin
            buzzing = 1'b0;
            beeps   = '0;
         end
      end
   endfunction

   function automatic void advance_tick();
      case (ph)
         PH_INITIATE: begin
            start_burst((tone_q == TONE_MEDIUM || tone_q == TONE_HIGH) ?
                        FIRST_BURST_BEEPS : '0, PH_ON);
         end
         PH_ON: begin
            if (count_expired()) end_beep(PH_OFF);
         end
         PH_OFF: begin
            if (count_expired()) begin
               if (beeps == 0) begin
                  buzzing = 1'b0;
                  if (tone_q == TONE_MEDIUM) begin
                     ph       = PH_PAUSE;
                     wait_cnt = tick_cnt[REG_PAUSE];
                  end else begin
                     ph       = PH_SPACE;
                     wait_cnt = tick_cnt[REG_SPACE];
                  end
               end else begin
                  ph       = PH_ON;
                  wait_cnt = tick_cnt[REG_ON];
                  buzzing  = 1'b1;
               end
            end
         end
         PH_SPACE: begin
            if (count_expired())
               start_burst((tone_q == TONE_HIGH) ? SECOND_BURST_BEEPS : '0, PH_ON2);
         end
         PH_ON2: begin
            if (count_expired()) end_beep(PH_OFF2);
         end
         PH_OFF2: begin
            if (count_expired()) begin
               if (beeps == 0) begin
                  buzzing  = 1'b0;
                  ph       = PH_PAUSE;
                  wait_cnt = tick_cnt[REG_PAUSE];
               end else begin
                  ph       = PH_ON2;
                  wait_cnt = tick_cnt[REG_ON];
                  buzzing  = 1'b1;
               end
            end
         end
         PH_PAUSE: begin
            if (count_expired()) ph = PH_INITIATE;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      logic [1:0] idx;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            ms_reg[i]   = '0;
            tick_cnt[i] = '0;
         end
         ph       = PH_INACTIVE;
         wait_cnt = '0;
         beeps    = '0;
         tone_q   = TONE_OFF;
         buzzing  = 1'b0;
         beep_expect_q.delete();
      end else begin
         // results leave before this edge's item could show up, so check first
         if (rsp_tvalid && rsp_tready) begin
            if (beep_expect_q.size() == 0) begin
               flag_mismatch("unexpected result", '0, 32'(rsp_tdata));
            end else begin
               want = beep_expect_q.pop_front();
               if (rsp_tdata[0] !== want.sound_on)
                  flag_mismatch("sound_on", 32'(want.sound_on), 32'(rsp_tdata[0]));
               if (rsp_tdata[8:1] !== want.pwm_compare)
                  flag_mismatch("pwm_compare", 32'(want.pwm_compare), 32'(rsp_tdata[8:1]));
               if (rsp_tdata[11:9] !== want.phase)
                  flag_mismatch("phase", 32'(want.phase), 32'(rsp_tdata[11:9]));
            end
         end
         if (csr_psel && csr_penable && csr_pready) begin
            idx = csr_paddr[3:2];
            if (csr_pwrite)
               ms_reg[idx] = csr_pwdata[REG_W-1:0];
            else if (csr_prdata !== 32'(ms_reg[idx]))
               flag_mismatch("register read", 32'(ms_reg[idx]), csr_prdata);
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0])
               tone_request(tone_type'(req_tdata[1:0]));
            else
               advance_tick();
            want.sound_on    = buzzing;
            want.pwm_compare = buzzing ? SOUND_DUTY : '0;
            want.phase       = ph;
            beep_expect_q.push_back(want);
         end
      end
      pending <= beep_expect_q.size();
   end

endmodule

// ----- test/alarm_beep_pattern_sequencer_test.sv -----
// Testbench top for the alarm beep pattern sequencer: clock, reset, register
// setup, directed and random tick/request items, random stalls and the verdict.
// Depends on abps_pkg, the block itself and abps_pattern_checker.
module alarm_beep_pattern_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import abps_pkg::*;

   localparam logic ACT_TICK      = 1'b0;
   localparam logic ACT_REQUEST   = 1'b1;
   localparam int   SETTLE_CYCLES = 4;
   localparam int   CYCLE_LIMIT   = 600000;
   localparam int   PHASES        = 8;
   localparam int   PHASE_ITEMS   = 170;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic [0:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int cycles   = 0;
   int rsp_hold = 0;
   bit no_idle  = 1'b0;

   alarm_beep_pattern_sequencer dut (.*);

   abps_pattern_checker u_checker (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 99) < 25) rsp_hold <= gap_len();
      end
   end

   function automatic logic [15:0] pick_ms();
      int r = $urandom_range(0, 99);
      if (r < 10) return 16'd0;
      if (r < 20) return 16'($urandom_range(1, 9));
      if (r < 25) return 16'hFFFF;
      if (r < 90) return 16'($urandom_range(5, 60));
      return 16'($urandom);
   endfunction

   function automatic tone_type pick_tone();
      int r = $urandom_range(0, 99);
      if (r < 40) return TONE_MEDIUM;
      if (r < 80) return TONE_HIGH;
      if (r < 90) return TONE_OFF;
      return TONE_INVALID;
   endfunction

   task automatic send_item(input logic action, input logic [1:0] tone);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {6'b0, tone};
      do @(posedge clock); while (!req_tready);
      gap = (!no_idle && $urandom_range(0, 99) < 30) ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // tone bits are don't-care on ticks, so they get random values
   task automatic run_ticks(input int n);
      repeat (n) send_item(ACT_TICK, 2'($urandom_range(0, 3)));
   endtask

   // hold off the sender until every item has produced its result
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input reg_idx_type idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {16'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] on_ms, off_ms, space_ms, pause_ms);
      logic [15:0] vals [NUM_REGS];
      settle();
      vals = '{on_ms, off_ms, space_ms, pause_ms};
      for (int i = 0; i < NUM_REGS; i++) csr_cycle(1'b1, reg_idx_type'(i), vals[i]);
      for (int i = 0; i < NUM_REGS; i++) csr_cycle(1'b0, reg_idx_type'(i), '0);
   endtask

   initial begin
      int req_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: tick while inactive, invalid and off requests, medium burst,
      // restart to high mid-run, invalid while sounding, then off
      configure(16'd10, 16'd5, 16'd15, 16'd0);
      run_ticks(1);
      send_item(ACT_REQUEST, TONE_INVALID);
      send_item(ACT_REQUEST, TONE_OFF);
      send_item(ACT_REQUEST, TONE_MEDIUM);
      run_ticks(10);
      send_item(ACT_REQUEST, TONE_HIGH);
      run_ticks(4);
      send_item(ACT_REQUEST, TONE_INVALID);
      run_ticks(1);
      send_item(ACT_REQUEST, TONE_OFF);
      // zero on time: initiate falls straight back to inactive
      configure(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(ACT_REQUEST, TONE_MEDIUM);
      run_ticks(2);
      // zero off time: stops after the first beep
      configure(16'd5, 16'd0, 16'd0, 16'd0);
      send_item(ACT_REQUEST, TONE_HIGH);
      run_ticks(3);

      for (int p = 0; p < PHASES; p++) begin
         no_idle = 1'b0;
         case (p)
            0:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            1:       configure(16'd5, 16'd5, 16'd5, 16'd5);
            default: configure(pick_ms(), pick_ms(), pick_ms(), pick_ms());
         endcase
         no_idle = (p == 3) || ($urandom_range(0, 4) == 0);
         req_pct = $urandom_range(2, 10);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 1) == 1)) settle();
            if ($urandom_range(0, 99) < req_pct)
               send_item(ACT_REQUEST, pick_tone());
            else
               run_ticks(1);
         end
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/abps_pkg.sv
rtl/abps_csr.sv
rtl/abps_in_stage.sv
rtl/abps_engine.sv
rtl/alarm_beep_pattern_sequencer.sv
test/abps_pattern_checker.sv
test/alarm_beep_pattern_sequencer_test.sv
